// ----- rtl/i2cts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Action, command and phase codes, length limit, and the types shared by the
// sequencer's modules.
// ----------------------------------------------------------------------------
package i2cts_pkg;

    localparam int unsigned LEN_W    = 8;
    localparam int unsigned ADDR_W   = 7;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned CMD_W    = 4;
    localparam int unsigned PHASE_W  = 2;

    localparam logic [LEN_W-1:0] MAX_LEN = 8'd255;

    // Input actions.
    localparam logic [ACT_W-1:0] ACT_START_WRITE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START_READ  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START_WTR   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BYTE_DONE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT     = 3'd4;

    // Controller commands.
    localparam logic [CMD_W-1:0] CMD_NONE                = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SINGLE_SEND         = 4'd1;
    localparam logic [CMD_W-1:0] CMD_BURST_SEND_START    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_BURST_SEND_CONT     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_BURST_SEND_FINISH   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SINGLE_RECEIVE      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_BURST_RECEIVE_START = 4'd6;
    localparam logic [CMD_W-1:0] CMD_BURST_RECEIVE_CONT  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_BURST_RECEIVE_FINISH = 4'd8;

    // Transfer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SEND = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RECV = 2'd2;
    localparam logic [PHASE_W-1:0] PH_TOUT = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] slave_addr;
        logic [LEN_W-1:0]  send_len;
        logic [LEN_W-1:0]  recv_len;
        logic [BYTE_W-1:0] send_byte;
        logic [BYTE_W-1:0] bus_rx_byte;
    } t_item;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              reset_controller;
        logic [ADDR_W-1:0] addr_out;
        logic              read_dir;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_data;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_data;
        logic              complete;
        logic              timed_out;
        logic              rejected;
    } t_result;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LEN_W-1:0]   bytes_left;
        logic               read_pending;
        logic [LEN_W-1:0]   pending_read_len;
        logic [ADDR_W-1:0]  target_addr;
    } t_state;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        clamp_len = (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

endpackage

// ----- rtl/i2cts_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer event channel
// Valid/ready channel carrying one event word into the sequencer.
// ----------------------------------------------------------------------------
interface i2cts_in_if;
    logic                            valid;
    logic                            ready;
    logic [i2cts_pkg::ACT_W-1:0]     action;
    logic [i2cts_pkg::ADDR_W-1:0]    slave_addr;
    logic [i2cts_pkg::LEN_W-1:0]     send_len;
    logic [i2cts_pkg::LEN_W-1:0]     recv_len;
    logic [i2cts_pkg::BYTE_W-1:0]    send_byte;
    logic [i2cts_pkg::BYTE_W-1:0]    bus_rx_byte;

    modport source (output valid, action, slave_addr, send_len, recv_len, send_byte,
                    bus_rx_byte, input ready);
    modport sink   (input valid, action, slave_addr, send_len, recv_len, send_byte,
                    bus_rx_byte, output ready);
endinterface

// ----- rtl/i2cts_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer result channel
// Valid/ready channel carrying one result word out of the sequencer.
// ----------------------------------------------------------------------------
interface i2cts_out_if;
    logic                            valid;
    logic                            ready;
    logic [i2cts_pkg::CMD_W-1:0]     command;
    logic                            reset_controller;
    logic [i2cts_pkg::ADDR_W-1:0]    addr_out;
    logic                            read_dir;
    logic                            tx_valid;
    logic [i2cts_pkg::BYTE_W-1:0]    tx_data;
    logic                            rx_valid;
    logic [i2cts_pkg::BYTE_W-1:0]    rx_data;
    logic                            complete;
    logic                            timed_out;
    logic                            rejected;

    modport source (output valid, command, reset_controller, addr_out, read_dir, tx_valid,
                    tx_data, rx_valid, rx_data, complete, timed_out, rejected,
                    input ready);
    modport sink   (input valid, command, reset_controller, addr_out, read_dir, tx_valid,
                    tx_data, rx_valid, rx_data, complete, timed_out, rejected,
                    output ready);
endinterface

// ----- rtl/i2cts_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer step logic
// Works out the next transfer state and the result word for one event.
// ----------------------------------------------------------------------------
module i2cts_step (
    input  i2cts_pkg::t_state  i_state,
    input  i2cts_pkg::t_item   i_item,
    output i2cts_pkg::t_state  o_state,
    output i2cts_pkg::t_result o_result,
    output logic               o_has_result
);

    logic                              busy;
    logic [i2cts_pkg::LEN_W-1:0]       slen;
    logic [i2cts_pkg::LEN_W-1:0]       rlen;
    logic [i2cts_pkg::LEN_W-1:0]       bl_dec;
    logic                              do_write;
    logic                              do_read;
    logic [i2cts_pkg::LEN_W-1:0]       rd_len;
    logic [i2cts_pkg::ADDR_W-1:0]      rd_addr;
    i2cts_pkg::t_state                 st;
    i2cts_pkg::t_result                res;
    logic                              has_res;

    assign busy   = (i_state.phase == i2cts_pkg::PH_SEND) ||
                    (i_state.phase == i2cts_pkg::PH_RECV);
    assign slen   = i2cts_pkg::clamp_len(i_item.send_len);
    assign rlen   = i2cts_pkg::clamp_len(i_item.recv_len);
    assign bl_dec = i_state.bytes_left - 1'b1;

    always_comb begin
        st       = i_state;
        res      = '0;
        has_res  = 1'b0;
        do_write = 1'b0;
        do_read  = 1'b0;
        rd_len   = rlen;
        rd_addr  = i_item.slave_addr;

        case (i_item.action)
            i2cts_pkg::ACT_START_WRITE, i2cts_pkg::ACT_START_READ,
            i2cts_pkg::ACT_START_WTR: begin
                has_res = 1'b1;
                if (busy) begin
                    res.rejected = 1'b1;
                end else if (i_item.action == i2cts_pkg::ACT_START_WRITE) begin
                    st.read_pending = 1'b0;
                    if (slen == '0) begin
                        res.complete = 1'b1;
                    end else begin
                        do_write = 1'b1;
                    end
                end else if (i_item.action == i2cts_pkg::ACT_START_READ || slen == '0) begin
                    // A write-then-read with nothing to write is a plain read.
                    st.read_pending = 1'b0;
                    do_read         = 1'b1;
                end else begin
                    st.read_pending     = 1'b1;
                    st.pending_read_len = rlen;
                    do_write            = 1'b1;
                end
            end
            i2cts_pkg::ACT_BYTE_DONE: begin
                if (i_state.phase == i2cts_pkg::PH_SEND) begin
                    has_res = 1'b1;
                    if (i_state.bytes_left == '0) begin
                        st.phase = i2cts_pkg::PH_IDLE;
                        if (i_state.read_pending) begin
                            st.read_pending = 1'b0;
                            do_read         = 1'b1;
                            rd_len          = i_state.pending_read_len;
                            rd_addr         = i_state.target_addr;
                        end else begin
                            res.complete = 1'b1;
                        end
                    end else begin
                        st.bytes_left = bl_dec;
                        res.tx_valid  = 1'b1;
                        res.tx_data   = i_item.send_byte;
                        res.command   = (bl_dec != '0) ? i2cts_pkg::CMD_BURST_SEND_CONT
                                                       : i2cts_pkg::CMD_BURST_SEND_FINISH;
                    end
                end else if (i_state.phase == i2cts_pkg::PH_RECV) begin
                    has_res      = 1'b1;
                    res.rx_valid = 1'b1;
                    res.rx_data  = i_item.bus_rx_byte;
                    if (i_state.bytes_left <= 1) begin
                        st.bytes_left = '0;
                        st.phase      = i2cts_pkg::PH_IDLE;
                        res.complete  = 1'b1;
                    end else begin
                        st.bytes_left = bl_dec;
                        res.command   = (bl_dec > 1) ? i2cts_pkg::CMD_BURST_RECEIVE_CONT
                                                     : i2cts_pkg::CMD_BURST_RECEIVE_FINISH;
                    end
                end
            end
            i2cts_pkg::ACT_TIMEOUT: begin
                st.read_pending = 1'b0;
                st.phase        = i2cts_pkg::PH_TOUT;
                if (busy) begin
                    has_res       = 1'b1;
                    st.bytes_left = '0;
                    res.complete  = 1'b1;
                    res.timed_out = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_write) begin
            res.reset_controller = (i_state.phase == i2cts_pkg::PH_TOUT);
            st.target_addr       = i_item.slave_addr;
            st.bytes_left        = slen - 1'b1;
            st.phase             = i2cts_pkg::PH_SEND;
            res.command          = (slen == 1) ? i2cts_pkg::CMD_SINGLE_SEND
                                               : i2cts_pkg::CMD_BURST_SEND_START;
            res.addr_out         = i_item.slave_addr;
            res.read_dir         = 1'b0;
            res.tx_valid         = 1'b1;
            res.tx_data          = i_item.send_byte;
        end

        if (do_read) begin
            if (rd_len == '0) begin
                res.complete = 1'b1;
            end else begin
                // The phase seen here is the one left by the write, if any.
                res.reset_controller = (st.phase == i2cts_pkg::PH_TOUT);
                st.target_addr       = rd_addr;
                st.bytes_left        = rd_len;
                st.phase             = i2cts_pkg::PH_RECV;
                res.command          = (rd_len == 1) ? i2cts_pkg::CMD_SINGLE_RECEIVE
                                                     : i2cts_pkg::CMD_BURST_RECEIVE_START;
                res.addr_out         = rd_addr;
                res.read_dir         = 1'b1;
            end
        end
    end

    assign o_state      = st;
    assign o_result     = res;
    assign o_has_result = has_res;

endmodule

// ----- rtl/i2c_transfer_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer
// Turns start, byte-done and timeout events into I2C master byte commands.
// ----------------------------------------------------------------------------
// Usage: events enter on i_evt (start write, start read, start write-then-read,
// byte done, timeout) and results leave on o_res, both valid/ready channels.
// An accepted event word is held in an input register; once it can advance,
// the step logic updates the transfer state and, if the event produces a
// result, loads it into the output register, which drives o_res. One event
// can be taken every cycle while the receiver does not stall.
// Events that produce no result (byte done or timeout while not busy, unused
// codes) only update the state and never occupy the output register.
// When the receiver stalls, the output register holds its word and the input
// register holds the next event; i_evt.ready falls only while both are full
// and that event has a result to deliver.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// transfer state to idle with all counts cleared.
// ----------------------------------------------------------------------------
module i2c_transfer_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cts_in_if.sink     i_evt,
    i2cts_out_if.source  o_res
);

    logic                r_in_valid;
    i2cts_pkg::t_item    r_in;
    i2cts_pkg::t_state   r_state;
    i2cts_pkg::t_state   n_state;
    logic                r_out_valid;
    i2cts_pkg::t_result  r_out;
    i2cts_pkg::t_result  n_out;
    logic                has_res;
    logic                advance;
    logic                in_take;

    i2cts_step u_step (
        .i_state      (r_state),
        .i_item       (r_in),
        .o_state      (n_state),
        .o_result     (n_out),
        .o_has_result (has_res)
    );

    assign advance = r_in_valid && (!has_res || !r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || advance;
    assign in_take = i_evt.valid && i_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: i2cts_pkg::PH_IDLE, default: '0};
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && has_res) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.action      <= i_evt.action;
            r_in.slave_addr  <= i_evt.slave_addr;
            r_in.send_len    <= i_evt.send_len;
            r_in.recv_len    <= i_evt.recv_len;
            r_in.send_byte   <= i_evt.send_byte;
            r_in.bus_rx_byte <= i_evt.bus_rx_byte;
        end
        if (advance && has_res) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.command          = r_out.command;
    assign o_res.reset_controller = r_out.reset_controller;
    assign o_res.addr_out         = r_out.addr_out;
    assign o_res.read_dir         = r_out.read_dir;
    assign o_res.tx_valid         = r_out.tx_valid;
    assign o_res.tx_data          = r_out.tx_data;
    assign o_res.rx_valid         = r_out.rx_valid;
    assign o_res.rx_data          = r_out.rx_data;
    assign o_res.complete         = r_out.complete;
    assign o_res.timed_out        = r_out.timed_out;
    assign o_res.rejected         = r_out.rejected;

endmodule
